FILE: hdl/bus_mailbox_port_with_ram_core_defines.svh
// Assertion macros shared by the mailbox checker.
`ifndef BUS_MAILBOX_PORT_WITH_RAM_CORE_DEFINES_SVH
`define BUS_MAILBOX_PORT_WITH_RAM_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox check failed: same-cycle implication");

// Next-cycle implication, clocked on clk, off during reset.
`define BMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox check failed: next-cycle implication");

`endif

FILE: hdl/bmp_pkg.sv
// Shared constants and types of the bus mailbox port.
package bmp_pkg;

  localparam int CMD_DEPTH     = 136;
  localparam int RESP_DEPTH    = 131;
  localparam int RAM_ADDR_BITS = 16;

  localparam int CMD_AW  = $clog2(CMD_DEPTH);
  localparam int CMD_CW  = $clog2(CMD_DEPTH + 1);
  localparam int RESP_AW = $clog2(RESP_DEPTH);
  localparam int RESP_CW = $clog2(RESP_DEPTH + 1);
  localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

  typedef enum logic [3:0] {
    MODE_IO_WR      = 4'd0,
    MODE_IO_RD      = 4'd1,
    MODE_MEM_WR     = 4'd2,
    MODE_MEM_RD     = 4'd3,
    MODE_RESP_START = 4'd4,
    MODE_RESP_APPEND = 4'd5,
    MODE_RESP_FINISH = 4'd6,
    MODE_RESP_CLEAR = 4'd7,
    MODE_CMD_CLEAR  = 4'd8,
    MODE_CMD_READ   = 4'd9
  } mode_t;

endpackage

FILE: hdl/bmp_ifs.sv
// Channel interfaces of the bus mailbox port: request, result and configuration.
interface bmp_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic        port_select;
  logic [15:0] mem_address;
  logic [7:0]  command_index;
  logic [7:0]  data_byte;

  modport source (output valid, mode, port_select, mem_address, command_index, data_byte,
                  input ready);
  modport sink   (input valid, mode, port_select, mem_address, command_index, data_byte,
                  output ready);
  modport mon    (input valid, ready, mode, port_select, mem_address, command_index,
                  data_byte);
endinterface

interface bmp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] command_count;
  logic [7:0] staging_count;
  logic       response_pending;
  logic [7:0] video_byte;
  logic       video_valid;
  logic       overflow;
  logic       ignored;

  modport source (output valid, read_data, command_count, staging_count, response_pending,
                  video_byte, video_valid, overflow, ignored,
                  input ready);
  modport sink   (input valid, read_data, command_count, staging_count, response_pending,
                  video_byte, video_valid, overflow, ignored,
                  output ready);
  modport mon    (input valid, ready, read_data, command_count, staging_count,
                  response_pending, video_byte, video_valid, overflow, ignored);
endinterface

interface bmp_cfg_if;
  logic valid;
  logic ready;
  logic ram_enabled;

  modport source (output valid, ram_enabled, input ready);
  modport sink   (input valid, ram_enabled, output ready);
  modport mon    (input valid, ready, ram_enabled);
endinterface

FILE: hdl/bmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bus_mailbox_port_with_ram_core.sv
// Bus mailbox port core: command buffer, response buffer, video snoop and host RAM.
// Each request word is accepted in S_IDLE, where reads are issued to the command buffer,
// response buffer and host RAM; in S_EXEC the word then modifies state, writes back and
// loads the result register. A new word is taken only once the last has left S_EXEC,
// and a stalled result holds the core in S_EXEC. Accesses never overlap,
// so no forwarding is needed. No clearing pass after reset.
module bus_mailbox_port_with_ram_core (
  input  logic       clk,
  input  logic       rst_n,
  bmp_in_if.sink     in_if,
  bmp_out_if.source  out_if,
  bmp_cfg_if.sink    cfg_if
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;

  logic ram_en_r;

  // captured request
  bmp_pkg::mode_t mode_r;
  logic           port_r;
  logic           cidx_ok_r;
  logic [7:0]     data_r;
  logic [bmp_pkg::RAM_ADDR_BITS-1:0] addr_r;

  // mailbox state
  logic [bmp_pkg::CMD_CW-1:0]  cmd_fill_r, cmd_fill_nxt;
  logic [bmp_pkg::RESP_CW-1:0] stg_fill_r, stg_fill_nxt;
  logic [bmp_pkg::RESP_CW-1:0] total_r, total_nxt;
  logic [bmp_pkg::RESP_CW-1:0] pos_r, pos_nxt;
  logic                        pend_r, pend_nxt;
  logic [7:0]                  next_r, next_nxt;
  logic [7:0]                  snoop_r, snoop_nxt;
  logic                        seen_r, seen_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       ovf_r, ovf_nxt;
  logic       ign_r, ign_nxt;

  logic accept, done;
  logic cmd_full, stg_full;

  logic                         cmd_we;
  logic [7:0]                   cmd_rdata;
  logic                         resp_we;
  logic [bmp_pkg::RESP_AW-1:0]  resp_raddr;
  logic [7:0]                   resp_rdata;
  logic                         host_we;
  logic [7:0]                   host_rdata;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign accept = in_if.valid && in_if.ready;
  assign done   = (state_r == S_EXEC) && (!out_valid_r || out_if.ready);

  assign cmd_full = (cmd_fill_r >= bmp_pkg::CMD_CW'(bmp_pkg::CMD_DEPTH));
  assign stg_full = (stg_fill_r >= bmp_pkg::RESP_CW'(bmp_pkg::RESP_DEPTH));

  assign cmd_we  = done && (mode_r == bmp_pkg::MODE_IO_WR) && !port_r && !cmd_full;
  assign resp_we = done && (mode_r == bmp_pkg::MODE_RESP_APPEND) && !stg_full;
  assign host_we = done && (mode_r == bmp_pkg::MODE_MEM_WR) && ram_en_r;

  assign resp_raddr = (bmp_pkg::mode_t'(in_if.mode) == bmp_pkg::MODE_RESP_FINISH) ?
                      '0 : pos_r[bmp_pkg::RESP_AW-1:0];

  bmp_ram #(.WIDTH(8), .DEPTH(bmp_pkg::CMD_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (cmd_fill_r[bmp_pkg::CMD_AW-1:0]),
    .wdata (data_r),
    .re    (accept),
    .raddr (in_if.command_index[bmp_pkg::CMD_AW-1:0]),
    .rdata (cmd_rdata)
  );

  bmp_ram #(.WIDTH(8), .DEPTH(bmp_pkg::RESP_DEPTH)) u_resp_ram (
    .clk   (clk),
    .we    (resp_we),
    .waddr (stg_fill_r[bmp_pkg::RESP_AW-1:0]),
    .wdata (data_r),
    .re    (accept),
    .raddr (resp_raddr),
    .rdata (resp_rdata)
  );

  bmp_ram #(.WIDTH(8), .DEPTH(bmp_pkg::RAM_DEPTH)) u_host_ram (
    .clk   (clk),
    .we    (host_we),
    .waddr (addr_r),
    .wdata (data_r),
    .re    (accept),
    .raddr (in_if.mem_address[bmp_pkg::RAM_ADDR_BITS-1:0]),
    .rdata (host_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_fill_nxt = cmd_fill_r;
    stg_fill_nxt = stg_fill_r;
    total_nxt    = total_r;
    pos_nxt      = pos_r;
    pend_nxt     = pend_r;
    next_nxt     = next_r;
    snoop_nxt    = snoop_r;
    seen_nxt     = seen_r;
    rd_nxt       = rd_r;
    ovf_nxt      = ovf_r;
    ign_nxt      = ign_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    if (accept) begin
      state_nxt = S_EXEC;
    end

    if (done) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      rd_nxt        = 8'h00;
      ovf_nxt       = 1'b0;
      ign_nxt       = 1'b0;
      unique case (mode_r)
        bmp_pkg::MODE_IO_WR: begin
          if (port_r) begin
            snoop_nxt = data_r;
            seen_nxt  = 1'b1;
          end else if (cmd_full) begin
            ovf_nxt = 1'b1;
          end else begin
            cmd_fill_nxt = cmd_fill_r + 1'b1;
          end
        end
        bmp_pkg::MODE_IO_RD: begin
          if (!port_r) begin
            rd_nxt = next_r;
            if (pos_r >= total_r) begin
              total_nxt = '0;
              pos_nxt   = '0;
              pend_nxt  = 1'b0;
              next_nxt  = 8'h00;
            end else begin
              next_nxt = resp_rdata;
              pos_nxt  = pos_r + 1'b1;
            end
          end
        end
        bmp_pkg::MODE_MEM_WR: begin
          ign_nxt = !ram_en_r;
        end
        bmp_pkg::MODE_MEM_RD: begin
          ign_nxt = !ram_en_r;
          rd_nxt  = ram_en_r ? host_rdata : 8'h00;
        end
        bmp_pkg::MODE_RESP_START: begin
          stg_fill_nxt = '0;
        end
        bmp_pkg::MODE_RESP_APPEND: begin
          if (stg_full) begin
            ovf_nxt = 1'b1;
          end else begin
            stg_fill_nxt = stg_fill_r + 1'b1;
          end
        end
        bmp_pkg::MODE_RESP_FINISH: begin
          next_nxt  = resp_rdata;
          pos_nxt   = bmp_pkg::RESP_CW'(1);
          total_nxt = stg_fill_r;
          pend_nxt  = 1'b1;
        end
        bmp_pkg::MODE_RESP_CLEAR: begin
          total_nxt = '0;
          pos_nxt   = '0;
          pend_nxt  = 1'b0;
          next_nxt  = 8'h00;
        end
        bmp_pkg::MODE_CMD_CLEAR: begin
          cmd_fill_nxt = '0;
        end
        bmp_pkg::MODE_CMD_READ: begin
          rd_nxt = cidx_ok_r ? cmd_rdata : 8'h00;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ram_en_r    <= 1'b0;
      cmd_fill_r  <= '0;
      stg_fill_r  <= '0;
      total_r     <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      next_r      <= 8'h00;
      snoop_r     <= 8'h00;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_fill_r  <= cmd_fill_nxt;
      stg_fill_r  <= stg_fill_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      next_r      <= next_nxt;
      snoop_r     <= snoop_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        ram_en_r <= cfg_if.ram_enabled;
      end
    end
    rd_r  <= rd_nxt;
    ovf_r <= ovf_nxt;
    ign_r <= ign_nxt;
    if (accept) begin
      mode_r    <= bmp_pkg::mode_t'(in_if.mode);
      port_r    <= in_if.port_select;
      cidx_ok_r <= (in_if.command_index < 8'(bmp_pkg::CMD_DEPTH));
      addr_r    <= in_if.mem_address[bmp_pkg::RAM_ADDR_BITS-1:0];
      data_r    <= in_if.data_byte;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.read_data        = rd_r;
  assign out_if.command_count    = 8'(cmd_fill_r);
  assign out_if.staging_count    = 8'(stg_fill_r);
  assign out_if.response_pending = pend_r;
  assign out_if.video_byte       = snoop_r;
  assign out_if.video_valid      = seen_r;
  assign out_if.overflow         = ovf_r;
  assign out_if.ignored          = ign_r;

endmodule

FILE: hdl/bmp_checker.sv
// Port-level checks of the bus mailbox port core, bound into the core module.
`include "bus_mailbox_port_with_ram_core_defines.svh"

module bmp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [7:0] out_command_count,
  input logic [7:0] out_staging_count,
  input logic       out_overflow,
  input logic       out_ignored
);

  logic cmd_top, stg_top, fill_ok;

  assign cmd_top = (out_command_count == 8'(bmp_pkg::CMD_DEPTH));
  assign stg_top = (out_staging_count == 8'(bmp_pkg::RESP_DEPTH));
  assign fill_ok = (out_command_count <= 8'(bmp_pkg::CMD_DEPTH)) &&
                   (out_staging_count <= 8'(bmp_pkg::RESP_DEPTH));

  `BMP_ASSERT_NXT(a_one_word_in_flight, in_valid && in_ready, !in_ready)
  `BMP_ASSERT_IMP(a_ovf_needs_full, out_valid && out_overflow, cmd_top || stg_top)
  `BMP_ASSERT_IMP(a_ovf_ign_exclusive, out_valid, !(out_overflow && out_ignored))
  `BMP_ASSERT_IMP(a_fill_bounds, out_valid, fill_ok)
  `BMP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data))

endmodule

bind bus_mailbox_port_with_ram_core bmp_checker u_bmp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_read_data     (out_if.read_data),
  .out_command_count (out_if.command_count),
  .out_staging_count (out_if.staging_count),
  .out_overflow      (out_if.overflow),
  .out_ignored       (out_if.ignored)
);

FILE: test/bus_mailbox_port_with_ram_core_tb.sv
// Testbench for the bus mailbox port core: directed and random host and local traffic, checked word by word.
`timescale 1ns / 100ps

module bus_mailbox_port_with_ram_core_tb;

  localparam logic [3:0] MODE_SPARE_FIRST = 4'd10;
  localparam logic [3:0] MODE_SPARE_LAST  = 4'd15;
  localparam int         CYCLE_LIMIT      = 500000;
  localparam int         SETTLE_CYCLES    = 16;

  typedef struct packed {
    logic [3:0]  mode;
    logic        port_select;
    logic [15:0] mem_address;
    logic [7:0]  command_index;
    logic [7:0]  data_byte;
  } mbx_request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] command_count;
    logic [7:0] staging_count;
    logic       response_pending;
    logic [7:0] video_byte;
    logic       video_valid;
    logic       overflow;
    logic       ignored;
  } mbx_result_t;

  class mailbox_scoreboard;
    bit              ram_on;
    logic [7:0]      cmd_mem [bmp_pkg::CMD_DEPTH];
    logic [7:0]      resp_mem [bmp_pkg::RESP_DEPTH];
    logic [7:0]      ram_mem [bmp_pkg::RAM_DEPTH];
    bit              ram_set [bmp_pkg::RAM_DEPTH];
    logic [15:0]     ram_addrs [$];
    int              cmd_reach;
    int              resp_reach;
    logic [7:0]      cmd_fill;
    logic [7:0]      stage_fill;
    logic [7:0]      resp_total;
    logic [7:0]      resp_pos;
    logic [7:0]      next_byte;
    logic [7:0]      snoop;
    bit              pending;
    bit              snoop_seen;
    mbx_result_t     expected [$];
    int              errors;

    function new();
      ram_on     = 1'b0;
      cmd_reach  = 0;
      resp_reach = 0;
      cmd_fill   = '0;
      stage_fill = '0;
      snoop      = '0;
      snoop_seen = 1'b0;
      errors     = 0;
      drop_response();
    endfunction

    function void drop_response();
      resp_total = '0;
      resp_pos   = '0;
      pending    = 1'b0;
      next_byte  = '0;
    endfunction

    // 0 where the word would read a store entry that was never written
    function bit is_defined(mbx_request_t r);
      logic [15:0] a;
      a = r.mem_address & 16'(bmp_pkg::RAM_DEPTH - 1);
      case (r.mode)
        bmp_pkg::MODE_MEM_RD:      return !ram_on || ram_set[a];
        bmp_pkg::MODE_RESP_FINISH: return resp_reach > 0;
        bmp_pkg::MODE_CMD_READ:
          return r.command_index >= bmp_pkg::CMD_DEPTH || r.command_index < cmd_reach;
        default:                   return 1'b1;
      endcase
    endfunction

    function void note_request(mbx_request_t r);
      mbx_result_t e;
      logic [15:0] a;
      e = '0;
      a = r.mem_address & 16'(bmp_pkg::RAM_DEPTH - 1);
      case (r.mode)
        bmp_pkg::MODE_IO_WR: begin
          if (!r.port_select) begin
            if (cmd_fill < bmp_pkg::CMD_DEPTH) begin
              cmd_mem[cmd_fill] = r.data_byte;
              cmd_fill++;
              if (int'(cmd_fill) > cmd_reach) cmd_reach = int'(cmd_fill);
            end else begin
              e.overflow = 1'b1;
            end
          end else begin
            snoop      = r.data_byte;
            snoop_seen = 1'b1;
          end
        end
        bmp_pkg::MODE_IO_RD: begin
          if (!r.port_select) begin
            e.read_data = next_byte;
            if (resp_pos >= resp_total) begin
              drop_response();
            end else if (resp_pos < bmp_pkg::RESP_DEPTH) begin
              next_byte = resp_mem[resp_pos];
              resp_pos++;
            end
          end
        end
        bmp_pkg::MODE_MEM_WR: begin
          if (ram_on) begin
            ram_mem[a] = r.data_byte;
            if (!ram_set[a]) begin
              ram_set[a] = 1'b1;
              ram_addrs.push_back(a);
            end
          end else begin
            e.ignored = 1'b1;
          end
        end
        bmp_pkg::MODE_MEM_RD: begin
          if (ram_on) e.read_data = ram_mem[a];
          else e.ignored = 1'b1;
        end
        bmp_pkg::MODE_RESP_START: stage_fill = '0;
        bmp_pkg::MODE_RESP_APPEND: begin
          if (stage_fill < bmp_pkg::RESP_DEPTH) begin
            resp_mem[stage_fill] = r.data_byte;
            stage_fill++;
            if (int'(stage_fill) > resp_reach) resp_reach = int'(stage_fill);
          end else begin
            e.overflow = 1'b1;
          end
        end
        bmp_pkg::MODE_RESP_FINISH: begin
          next_byte  = resp_mem[0];
          resp_pos   = 8'd1;
          resp_total = stage_fill;
          pending    = 1'b1;
        end
        bmp_pkg::MODE_RESP_CLEAR: drop_response();
        bmp_pkg::MODE_CMD_CLEAR:  cmd_fill = '0;
        bmp_pkg::MODE_CMD_READ: begin
          if (r.command_index < bmp_pkg::CMD_DEPTH) e.read_data = cmd_mem[r.command_index];
        end
        default: ;
      endcase
      e.command_count    = cmd_fill;
      e.staging_count    = stage_fill;
      e.response_pending = pending;
      e.video_byte       = snoop;
      e.video_valid      = snoop_seen;
      expected.push_back(e);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] have);
      if (have !== want) begin
        $error("%s: expected 0x%02h, got 0x%02h", field, want, have);
        errors++;
      end
    endfunction

    function void check_result(mbx_result_t got);
      mbx_result_t e;
      if (expected.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      e = expected.pop_front();
      compare_field("read_data", e.read_data, got.read_data);
      compare_field("command_count", e.command_count, got.command_count);
      compare_field("staging_count", e.staging_count, got.staging_count);
      compare_field("response_pending", 8'(e.response_pending), 8'(got.response_pending));
      compare_field("video_byte", e.video_byte, got.video_byte);
      compare_field("video_valid", 8'(e.video_valid), 8'(got.video_valid));
      compare_field("overflow", 8'(e.overflow), 8'(got.overflow));
      compare_field("ignored", 8'(e.ignored), 8'(got.ignored));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bmp_in_if  in_bus();
  bmp_out_if out_bus();
  bmp_cfg_if cfg_bus();

  bus_mailbox_port_with_ram_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  mailbox_scoreboard sb;
  mbx_result_t       result_seen;
  int                cycle_count = 0;
  int                burst_left  = 0;
  int                phase_count = 0;
  int                rdy_style   = 0;
  int                style_left  = 0;
  int                stall_left  = 0;
  bit                rdy_next;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // result side: check accepted words, then pick next ready from the current stall style
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      result_seen.read_data        = out_bus.read_data;
      result_seen.command_count    = out_bus.command_count;
      result_seen.staging_count    = out_bus.staging_count;
      result_seen.response_pending = out_bus.response_pending;
      result_seen.video_byte       = out_bus.video_byte;
      result_seen.video_valid      = out_bus.video_valid;
      result_seen.overflow         = out_bus.overflow;
      result_seen.ignored          = out_bus.ignored;
      sb.check_result(result_seen);
    end
    if (style_left == 0) begin
      rdy_style  = $urandom_range(0, 2);
      style_left = $urandom_range(50, 300);
    end
    style_left--;
    case (rdy_style)
      0: rdy_next = 1'b1;
      1: rdy_next = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rdy_next = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 12);
          rdy_next   = 1'b0;
        end else begin
          rdy_next = 1'b1;
        end
      end
    endcase
    out_bus.ready <= rdy_next;
  end

  function automatic mbx_request_t random_req(input logic [3:0] mode);
    mbx_request_t r;
    r.mode          = mode;
    r.port_select   = 1'($urandom_range(0, 1));
    r.mem_address   = 16'($urandom_range(0, 16'hFFFF));
    r.command_index = 8'($urandom_range(0, 8'hFF));
    r.data_byte     = 8'($urandom_range(0, 8'hFF));
    return r;
  endfunction

  task automatic send_word(input mbx_request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= r.mode;
    in_bus.port_select   <= r.port_select;
    in_bus.mem_address   <= r.mem_address;
    in_bus.command_index <= r.command_index;
    in_bus.data_byte     <= r.data_byte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(r);
    if (r.mode <= bmp_pkg::MODE_CMD_READ && !(r.mode == bmp_pkg::MODE_IO_RD && r.port_select)
        && !((r.mode == bmp_pkg::MODE_MEM_WR || r.mode == bmp_pkg::MODE_MEM_RD)
             && !sb.ram_on))
      phase_count++;
  endtask

  task automatic issue(input logic [3:0] mode, input bit port, input logic [15:0] addr,
                       input logic [7:0] idx, input logic [7:0] data);
    mbx_request_t r;
    r.mode          = mode;
    r.port_select   = port;
    r.mem_address   = addr;
    r.command_index = idx;
    r.data_byte     = data;
    send_word(r);
  endtask

  task automatic wait_results_done();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.expected.size() != 0);
  endtask

  task automatic write_ram_enable(input bit value);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.ram_enabled <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    sb.ram_on = value;
  endtask

  task automatic cmd_sequence(input bit to_overflow);
    mbx_request_t r;
    int n;
    n = to_overflow ? bmp_pkg::CMD_DEPTH - int'(sb.cmd_fill) + int'($urandom_range(1, 4))
                    : int'($urandom_range(1, 10));
    repeat (n) begin
      r = random_req(bmp_pkg::MODE_IO_WR);
      r.port_select = 1'b0;
      send_word(r);
    end
    repeat ($urandom_range(0, 6)) begin
      r = random_req(bmp_pkg::MODE_CMD_READ);
      if (sb.cmd_reach > 0 && $urandom_range(0, 4) != 0)
        r.command_index = 8'($urandom_range(0, sb.cmd_reach - 1));
      else
        r.command_index = 8'($urandom_range(bmp_pkg::CMD_DEPTH, 8'hFF));
      send_word(r);
    end
    if (sb.cmd_fill > bmp_pkg::CMD_DEPTH / 2 || $urandom_range(0, 3) == 0)
      send_word(random_req(bmp_pkg::MODE_CMD_CLEAR));
  endtask

  task automatic resp_sequence(input bit to_overflow);
    mbx_request_t r;
    int n;
    int reads;
    int cut;
    if ($urandom_range(0, 7) != 0) send_word(random_req(bmp_pkg::MODE_RESP_START));
    n = to_overflow ? bmp_pkg::RESP_DEPTH + int'($urandom_range(1, 3))
                    : int'($urandom_range(0, 8));
    repeat (n) send_word(random_req(bmp_pkg::MODE_RESP_APPEND));
    if (sb.resp_reach == 0) return;
    send_word(random_req(bmp_pkg::MODE_RESP_FINISH));
    reads = int'(sb.resp_total) + int'($urandom_range(1, 3));
    cut   = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, reads - 1)) : -1;
    for (int i = 0; i < reads; i++) begin
      if (i == cut) send_word(random_req(bmp_pkg::MODE_RESP_CLEAR));
      if ($urandom_range(0, 9) == 0) begin
        r = random_req(bmp_pkg::MODE_IO_WR);
        r.port_select = 1'b1;
        send_word(r);
      end
      r = random_req(bmp_pkg::MODE_IO_RD);
      r.port_select = 1'b0;
      send_word(r);
    end
  endtask

  task automatic mem_sequence();
    mbx_request_t r;
    repeat ($urandom_range(1, 6)) begin
      r = random_req(bmp_pkg::MODE_MEM_WR);
      if (sb.ram_addrs.size() > 0 && $urandom_range(0, 3) == 0)
        r.mem_address = sb.ram_addrs[$urandom_range(0, sb.ram_addrs.size() - 1)];
      send_word(r);
    end
    repeat ($urandom_range(1, 6)) begin
      r = random_req(bmp_pkg::MODE_MEM_RD);
      if (sb.ram_on && sb.ram_addrs.size() > 0)
        r.mem_address = sb.ram_addrs[$urandom_range(0, sb.ram_addrs.size() - 1)];
      if (sb.is_defined(r)) send_word(r);
    end
  endtask

  task automatic noise_sequence();
    mbx_request_t r;
    logic [3:0] m;
    repeat ($urandom_range(1, 8)) begin
      m = 4'($urandom_range(0, MODE_SPARE_LAST));
      r = random_req(m);
      if (!sb.is_defined(r)) begin
        r.mode        = bmp_pkg::MODE_IO_WR;
        r.port_select = 1'b1;
      end
      send_word(r);
    end
  endtask

  task automatic random_phase(input bit ram_value, input int target, input bit long_cmd);
    int pick;
    wait_results_done();
    write_ram_enable(ram_value);
    phase_count = 0;
    if (long_cmd) cmd_sequence(1'b1);
    else resp_sequence(1'b1);
    while (phase_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) cmd_sequence($urandom_range(0, 39) == 0);
      else if (pick < 58) resp_sequence($urandom_range(0, 39) == 0);
      else if (pick < 80) mem_sequence();
      else noise_sequence();
      if ($urandom_range(0, 29) == 0) wait_results_done();
    end
  endtask

  initial begin
    sb = new();
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.mode          <= bmp_pkg::MODE_IO_WR;
    in_bus.port_select   <= 1'b0;
    in_bus.mem_address   <= '0;
    in_bus.command_index <= '0;
    in_bus.data_byte     <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.ram_enabled  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_ram_enable(1'b0);
    // read with nothing pending, command fill, snoop, unclaimed read, RAM off, command reads
    issue(bmp_pkg::MODE_IO_RD, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_IO_WR, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_IO_WR, 1'b0, 16'hFFFF, 8'hFF, 8'hFF);
    issue(bmp_pkg::MODE_IO_WR, 1'b1, 16'h0000, 8'h00, 8'hA5);
    issue(bmp_pkg::MODE_IO_RD, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
    issue(bmp_pkg::MODE_MEM_WR, 1'b0, 16'hFFFF, 8'h00, 8'h5A);
    issue(bmp_pkg::MODE_MEM_RD, 1'b1, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_CMD_READ, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_CMD_READ, 1'b0, 16'h0000, 8'h01, 8'h00);
    issue(bmp_pkg::MODE_CMD_READ, 1'b0, 16'h0000, 8'hFF, 8'h00);
    // two-byte response read past its end
    issue(bmp_pkg::MODE_RESP_START, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_RESP_APPEND, 1'b0, 16'h0000, 8'h00, 8'hFF);
    issue(bmp_pkg::MODE_RESP_APPEND, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_RESP_FINISH, 1'b0, 16'h0000, 8'h00, 8'h00);
    repeat (3) issue(bmp_pkg::MODE_IO_RD, 1'b0, 16'h0000, 8'h00, 8'h00);
    // finish with empty staging, then clears and spare modes
    issue(bmp_pkg::MODE_RESP_START, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_RESP_FINISH, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_IO_RD, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_RESP_FINISH, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_RESP_CLEAR, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_CMD_CLEAR, 1'b0, 16'h0000, 8'h00, 8'h00);
    issue(MODE_SPARE_FIRST, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
    issue(MODE_SPARE_LAST, 1'b0, 16'h0000, 8'h00, 8'h00);
    wait_results_done();
    write_ram_enable(1'b1);
    issue(bmp_pkg::MODE_MEM_WR, 1'b0, 16'hFFFF, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_MEM_WR, 1'b0, 16'h0000, 8'h00, 8'hFF);
    issue(bmp_pkg::MODE_MEM_RD, 1'b0, 16'hFFFF, 8'h00, 8'h00);
    issue(bmp_pkg::MODE_MEM_RD, 1'b0, 16'h0000, 8'h00, 8'h00);

    random_phase(1'b1, 300, 1'b1);
    random_phase(1'b0, 200, 1'b0);
    random_phase(1'b1, 300, 1'b0);
    random_phase(1'b1, 300, 1'b1);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bmp_pkg.sv
hdl/bmp_ifs.sv
hdl/bmp_ram.sv
hdl/bus_mailbox_port_with_ram_core.sv
hdl/bmp_checker.sv
test/bus_mailbox_port_with_ram_core_tb.sv
